@@ rtl/i2cm_pkg.sv @@
// shared types, codes and constants of the i2c register access master
`default_nettype none

package i2cm_pkg;

    localparam int          MAX_READ_DEF    = 256;
    localparam int          CFG_W           = 16;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd100;
    localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
    localparam logic [3:0]  BIT_LAST        = 4'd8;

    localparam logic [1:0]  ACT_WRITE = 2'd1;
    localparam logic [1:0]  ACT_READ  = 2'd2;

    localparam logic        CFG_PHASE_TICKS = 1'b0;
    localparam logic        CFG_ACK_TIMEOUT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'd0,
        ST_START_A  = 5'd1,
        ST_RSTART_A = 5'd2,
        ST_START_B  = 5'd3,
        ST_START_C  = 5'd4,
        ST_START_D  = 5'd5,
        ST_TX_L1    = 5'd6,
        ST_TX_L2    = 5'd7,
        ST_TX_L3    = 5'd8,
        ST_TX_H     = 5'd9,
        ST_TX_T     = 5'd10,
        ST_ACK_A    = 5'd11,
        ST_ACK_B    = 5'd12,
        ST_ACK_POLL = 5'd13,
        ST_RX_L     = 5'd14,
        ST_RX_H     = 5'd15,
        ST_MACK_A   = 5'd16,
        ST_MACK_B   = 5'd17,
        ST_MNACK_A  = 5'd18,
        ST_MNACK_B  = 5'd19,
        ST_STOP_A   = 5'd20,
        ST_STOP_B   = 5'd21,
        ST_STOP_C   = 5'd22
    } seq_state_t;

    typedef enum logic [2:0] {
        RL_W_DEV  = 3'd0,
        RL_W_REG  = 3'd1,
        RL_W_DATA = 3'd2,
        RL_R_DEV  = 3'd3,
        RL_R_REG  = 3'd4,
        RL_R_DEV1 = 3'd5,
        RL_STOP   = 3'd6,
        RL_FAULT  = 3'd7
    } byte_role_t;

    typedef struct packed {
        seq_state_t  seq;
        logic [15:0] phase_cnt;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift;
        logic [7:0]  poll_cnt;
        logic [7:0]  held_dev;
        logic [7:0]  held_reg;
        logic [7:0]  held_data;
        byte_role_t  role;
    } i2cm_state_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_byte;
        logic [8:0] read_count;
        logic       sda_in;
    } i2cm_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_input_mode;
        logic       busy_res;
        logic       done_res;
        logic       ack_fault;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
    } i2cm_res_t;

    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [7:0]  ack_timeout;
    } i2cm_cfg_t;

endpackage

`default_nettype wire

@@ rtl/i2cm_in_if.sv @@
// command channel carrying one bus tick item
`default_nettype none

interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_byte;
    logic [8:0] read_count;
    logic       sda_in;

    modport source (
        output valid, action, device_address, register_address, write_byte,
               read_count, sda_in,
        input  ready
    );
    modport sink (
        input  valid, action, device_address, register_address, write_byte,
               read_count, sda_in,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/i2cm_out_if.sv @@
// result channel carrying bus levels and status of one tick
`default_nettype none

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sda_input_mode;
    logic       busy_res;
    logic       done_res;
    logic       ack_fault;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;

    modport source (
        output valid, scl_out, sda_out, sda_input_mode, busy_res, done_res,
               ack_fault, read_byte, read_valid, read_last,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, sda_input_mode, busy_res, done_res,
               ack_fault, read_byte, read_valid, read_last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/i2cm_step.sv @@
// next-state and bus level logic for one tick of the i2c sequencer
`default_nettype none

module i2cm_step #(
    parameter int MAX_READ = i2cm_pkg::MAX_READ_DEF,
    parameter int BL_W     = $clog2(MAX_READ + 1)
) (
    input  i2cm_pkg::i2cm_state_t cur,
    input  logic [BL_W-1:0]       bytes_left,
    input  i2cm_pkg::i2cm_item_t  item,
    input  i2cm_pkg::i2cm_cfg_t   cfg,
    output i2cm_pkg::i2cm_state_t nxt,
    output logic [BL_W-1:0]       bytes_left_next,
    output i2cm_pkg::i2cm_res_t   res
);
    import i2cm_pkg::*;

    logic [15:0]     phase_len;
    logic            phase_done;
    logic [15:0]     phase_inc;
    logic [3:0]      bit_inc;
    logic [7:0]      rx_byte;
    logic [BL_W-1:0] bl_dec;
    logic [BL_W-1:0] bl_sat;
    logic            done;
    logic            fault;
    logic            rvalid;
    logic            rlast;

    // a phase length of zero behaves as one
    assign phase_len  = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
    assign phase_done = ({1'b0, cur.phase_cnt} + 17'd1) >= {1'b0, phase_len};
    assign phase_inc  = cur.phase_cnt + 16'd1;
    assign bit_inc    = cur.bit_cnt + 4'd1;
    assign rx_byte    = {cur.shift[6:0], item.sda_in};
    assign bl_dec     = (bytes_left != '0) ? bytes_left - BL_W'(1) : bytes_left;
    assign bl_sat     = (32'(item.read_count) > 32'(MAX_READ))
                        ? BL_W'(MAX_READ) : BL_W'(item.read_count);

    always_comb
    begin
        nxt             = cur;
        bytes_left_next = bytes_left;
        done            = 1'b0;
        fault           = 1'b0;
        rvalid          = 1'b0;
        rlast           = 1'b0;
        case (cur.seq)
            ST_IDLE:
            begin
                if (item.action == ACT_WRITE || item.action == ACT_READ)
                begin
                    nxt.held_dev    = item.device_address;
                    nxt.held_reg    = item.register_address;
                    nxt.held_data   = item.write_byte;
                    nxt.role        = (item.action == ACT_WRITE) ? RL_W_DEV : RL_R_DEV;
                    bytes_left_next = (item.action == ACT_READ) ? bl_sat : '0;
                    nxt.seq         = ST_START_A;
                    nxt.phase_cnt   = '0;
                end
            end
            ST_ACK_POLL:
            begin
                if (!item.sda_in)
                begin
                    // slave acknowledged: move on to the next byte of the transaction
                    nxt.phase_cnt = '0;
                    case (cur.role)
                        RL_W_DEV:
                        begin
                            nxt.role    = RL_W_REG;
                            nxt.shift   = cur.held_reg;
                            nxt.bit_cnt = '0;
                            nxt.seq     = ST_TX_L1;
                        end
                        RL_W_REG:
                        begin
                            nxt.role    = RL_W_DATA;
                            nxt.shift   = cur.held_data;
                            nxt.bit_cnt = '0;
                            nxt.seq     = ST_TX_L1;
                        end
                        RL_R_DEV:
                        begin
                            nxt.role    = RL_R_REG;
                            nxt.shift   = cur.held_reg;
                            nxt.bit_cnt = '0;
                            nxt.seq     = ST_TX_L1;
                        end
                        RL_R_REG:
                        begin
                            nxt.role = RL_R_DEV1;
                            nxt.seq  = ST_RSTART_A;
                        end
                        RL_R_DEV1:
                        begin
                            nxt.bit_cnt = '0;
                            nxt.shift   = '0;
                            nxt.seq     = (bytes_left != '0) ? ST_RX_L : ST_MNACK_A;
                        end
                        default:
                        begin
                            nxt.role = RL_STOP;
                            nxt.seq  = ST_STOP_A;
                        end
                    endcase
                end
                else if (cur.poll_cnt >= cfg.ack_timeout)
                begin
                    nxt.role      = RL_FAULT;
                    nxt.seq       = ST_STOP_A;
                    nxt.phase_cnt = '0;
                end
                else
                begin
                    nxt.poll_cnt = cur.poll_cnt + 8'd1;
                end
            end
            default:
            begin
                if (!phase_done)
                begin
                    nxt.phase_cnt = phase_inc;
                end
                else
                begin
                    nxt.phase_cnt = '0;
                    case (cur.seq)
                        ST_START_A,
                        ST_RSTART_A: nxt.seq = ST_START_B;
                        ST_START_B:  nxt.seq = ST_START_C;
                        ST_START_C:  nxt.seq = ST_START_D;
                        ST_START_D:
                        begin
                            nxt.shift   = (cur.role == RL_R_DEV1)
                                          ? (cur.held_dev | 8'h01) : cur.held_dev;
                            nxt.bit_cnt = '0;
                            nxt.seq     = ST_TX_L1;
                        end
                        ST_TX_L1: nxt.seq = ST_TX_L2;
                        ST_TX_L2: nxt.seq = ST_TX_L3;
                        ST_TX_L3: nxt.seq = ST_TX_H;
                        ST_TX_H:  nxt.seq = ST_TX_T;
                        ST_TX_T:
                        begin
                            nxt.shift   = {cur.shift[6:0], 1'b0};
                            nxt.bit_cnt = bit_inc;
                            if (bit_inc >= BIT_LAST)
                            begin
                                nxt.poll_cnt = '0;
                                nxt.seq      = ST_ACK_A;
                            end
                            else
                            begin
                                nxt.seq = ST_TX_L1;
                            end
                        end
                        ST_ACK_A: nxt.seq = ST_ACK_B;
                        ST_ACK_B: nxt.seq = ST_ACK_POLL;
                        ST_RX_L:  nxt.seq = ST_RX_H;
                        ST_RX_H:
                        begin
                            nxt.shift   = rx_byte;
                            nxt.bit_cnt = bit_inc;
                            if (bit_inc >= BIT_LAST)
                            begin
                                rvalid          = 1'b1;
                                rlast           = (bytes_left <= BL_W'(1));
                                bytes_left_next = bl_dec;
                                nxt.seq         = (bl_dec != '0) ? ST_MACK_A : ST_MNACK_A;
                            end
                            else
                            begin
                                nxt.seq = ST_RX_L;
                            end
                        end
                        ST_MACK_A: nxt.seq = ST_MACK_B;
                        ST_MACK_B:
                        begin
                            nxt.bit_cnt = '0;
                            nxt.shift   = '0;
                            nxt.seq     = ST_RX_L;
                        end
                        ST_MNACK_A: nxt.seq = ST_MNACK_B;
                        ST_MNACK_B:
                        begin
                            nxt.role = RL_STOP;
                            nxt.seq  = ST_STOP_A;
                        end
                        ST_STOP_A: nxt.seq = ST_STOP_B;
                        ST_STOP_B: nxt.seq = ST_STOP_C;
                        ST_STOP_C:
                        begin
                            done     = 1'b1;
                            fault    = (cur.role == RL_FAULT);
                            nxt.role = RL_W_DEV;
                            nxt.seq  = ST_IDLE;
                        end
                        default: nxt.seq = ST_IDLE;
                    endcase
                end
            end
        endcase
    end

    // bus levels follow the state after this tick's update
    always_comb
    begin
        res                = '0;
        res.scl_out        = 1'b1;
        res.sda_out        = 1'b1;
        res.sda_input_mode = 1'b0;
        case (nxt.seq)
            ST_RSTART_A:
            begin
                res.scl_out = 1'b0;
            end
            ST_START_C:
            begin
                res.sda_out = 1'b0;
            end
            ST_START_D, ST_MACK_A, ST_STOP_A:
            begin
                res.scl_out = 1'b0;
                res.sda_out = 1'b0;
            end
            ST_TX_L1, ST_TX_L2, ST_TX_L3, ST_TX_T:
            begin
                res.scl_out = 1'b0;
                res.sda_out = nxt.shift[7];
            end
            ST_TX_H:
            begin
                res.sda_out = nxt.shift[7];
            end
            ST_ACK_A, ST_RX_L:
            begin
                res.scl_out        = 1'b0;
                res.sda_input_mode = 1'b1;
            end
            ST_ACK_B, ST_ACK_POLL, ST_RX_H:
            begin
                res.sda_input_mode = 1'b1;
            end
            ST_MACK_B, ST_STOP_B:
            begin
                res.sda_out = 1'b0;
            end
            ST_MNACK_A:
            begin
                res.scl_out = 1'b0;
            end
            default:
            begin
                res.scl_out = 1'b1;
            end
        endcase
        res.busy_res   = (nxt.seq != ST_IDLE);
        res.done_res   = done;
        res.ack_fault  = fault;
        res.read_byte  = rvalid ? nxt.shift : 8'd0;
        res.read_valid = rvalid;
        res.read_last  = rlast;
    end

endmodule

`default_nettype wire

@@ rtl/i2c_master_register_access_top.sv @@
// i2c register access master: input register, sequencer state and result register
`default_nettype none

// I2C master that runs a register write (START, device address, register address,
// data, STOP) or a register read (START, device address, register address, repeated
// START, read address, read_count bytes with ACK/NACK, STOP). Every command-channel
// transaction is one bus tick and yields exactly one result transaction with the SCL
// and SDA levels and status of that tick. A tick is accepted every cycle as long as
// results are taken; it waits in the input register until its result has room, then
// passes to the output register. The sequencer state register is updated once per
// tick by a single pass through the step logic. Bus phase length and acknowledge
// timeout are set via the write port, by the user only while idle (not checked).

module i2c_master_register_access_top #(
    parameter int MAX_READ = i2cm_pkg::MAX_READ_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    i2cm_in_if.sink                      in_ch,
    i2cm_out_if.source                   out_ch,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [i2cm_pkg::CFG_W-1:0] cfg_wdata
);
    import i2cm_pkg::*;

    localparam int BL_W = $clog2(MAX_READ + 1);

    i2cm_cfg_t       cfg_reg;
    i2cm_item_t      item_reg;
    logic            item_vld_reg;
    i2cm_state_t     state_reg;
    i2cm_state_t     state_next;
    logic [BL_W-1:0] bytes_left_reg;
    logic [BL_W-1:0] bytes_left_next;
    i2cm_res_t       res_reg;
    i2cm_res_t       res_next;
    logic            out_vld_reg;
    logic            advance;

    // a tick moves through the step logic when its result has room
    assign advance      = item_vld_reg && (!out_vld_reg || out_ch.ready);
    assign in_ch.ready  = !item_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_ticks <= PHASE_TICKS_RST;
            cfg_reg.ack_timeout <= ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_TICKS: cfg_reg.phase_ticks <= cfg_wdata[15:0];
                CFG_ACK_TIMEOUT: cfg_reg.ack_timeout <= cfg_wdata[7:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_ch.valid && in_ch.ready)
        begin
            item_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.action           <= in_ch.action;
            item_reg.device_address   <= in_ch.device_address;
            item_reg.register_address <= in_ch.register_address;
            item_reg.write_byte       <= in_ch.write_byte;
            item_reg.read_count       <= in_ch.read_count;
            item_reg.sda_in           <= in_ch.sda_in;
        end
    end

    i2cm_step #(
        .MAX_READ (MAX_READ),
        .BL_W     (BL_W)
    ) u_step (
        .cur             (state_reg),
        .bytes_left      (bytes_left_reg),
        .item            (item_reg),
        .cfg             (cfg_reg),
        .nxt             (state_next),
        .bytes_left_next (bytes_left_next),
        .res             (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '0;
            bytes_left_reg <= '0;
        end
        else if (advance)
        begin
            state_reg      <= state_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.scl_out        = res_reg.scl_out;
    assign out_ch.sda_out        = res_reg.sda_out;
    assign out_ch.sda_input_mode = res_reg.sda_input_mode;
    assign out_ch.busy_res       = res_reg.busy_res;
    assign out_ch.done_res       = res_reg.done_res;
    assign out_ch.ack_fault      = res_reg.ack_fault;
    assign out_ch.read_byte      = res_reg.read_byte;
    assign out_ch.read_valid     = res_reg.read_valid;
    assign out_ch.read_last      = res_reg.read_last;

    // a fault is only ever reported together with the end of a transaction
    a_fault_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.ack_fault) |-> res_reg.done_res)
        else $error("ack fault reported without done");

    // a received byte never coincides with the final stop
    a_no_read_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> !(res_reg.done_res && res_reg.read_valid))
        else $error("read byte and done on the same tick");

    // idle always holds a cleared phase counter
    a_idle_phase_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.seq == ST_IDLE) |-> (state_reg.phase_cnt == 16'd0))
        else $error("phase counter running while idle");

    // the bit counter never runs past a full byte
    a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_cnt <= BIT_LAST)
        else $error("bit counter past eight");

    // a tick that passes the step logic leaves a result behind on the next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("result register empty after a step");

endmodule

`default_nettype wire

@@ tb/sv/tb_i2c_master_register_access_top.sv @@
// testbench for the i2c register access master: bus tick stimulus and level checks
`timescale 1ns / 100ps

module tb_i2c_master_register_access_top;
    import i2cm_pkg::*;

    localparam logic [1:0]  ACT_TICK          = 2'd0;
    localparam logic [1:0]  ACT_UNUSED        = 2'd3;
    localparam int          ITEM_TARGET       = 1100;
    localparam int          PHASE_ITEMS       = 150;
    localparam int          RESET_PHASE_TICKS = 104;
    localparam int unsigned CYCLE_LIMIT       = 100_000;

    // tracks the sequencer tick by tick and holds the bus levels still to come
    class bus_level_scoreboard;
        logic [15:0] phase_len;
        logic [7:0]  ack_limit;
        seq_state_t  seq;
        logic [15:0] phase_cnt;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift;
        logic [8:0]  left;
        logic [7:0]  poll_cnt;
        logic [7:0]  held_dev;
        logic [7:0]  held_reg;
        logic [7:0]  held_data;
        byte_role_t  role;
        i2cm_res_t   expected_levels[$];
        int unsigned mismatches;

        function new();
            phase_len  = PHASE_TICKS_RST;
            ack_limit  = ACK_TIMEOUT_RST;
            seq        = ST_IDLE;
            phase_cnt  = '0;
            bit_cnt    = '0;
            shift      = '0;
            left       = '0;
            poll_cnt   = '0;
            held_dev   = '0;
            held_reg   = '0;
            held_data  = '0;
            role       = RL_W_DEV;
            mismatches = 0;
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == CFG_PHASE_TICKS)
                phase_len = val;
            else
                ack_limit = val[7:0];
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        function void go(seq_state_t st);
            seq       = st;
            phase_cnt = '0;
        endfunction

        // zero phase length behaves as one tick
        function bit phase_done();
            int unsigned len;
            int unsigned nxt;
            len = (phase_len == 0) ? 1 : phase_len;
            nxt = phase_cnt + 32'd1;
            if (nxt >= len)
            begin
                phase_cnt = '0;
                return 1'b1;
            end
            phase_cnt = 16'(nxt);
            return 1'b0;
        endfunction

        function void send_byte(logic [7:0] b, byte_role_t r);
            role    = r;
            shift   = b;
            bit_cnt = '0;
            go(ST_TX_L1);
        endfunction

        function void acked();
            case (role)
                RL_W_DEV: send_byte(held_reg, RL_W_REG);
                RL_W_REG: send_byte(held_data, RL_W_DATA);
                RL_R_DEV: send_byte(held_reg, RL_R_REG);
                RL_R_REG:
                begin
                    role = RL_R_DEV1;
                    go(ST_RSTART_A);
                end
                RL_R_DEV1:
                begin
                    bit_cnt = '0;
                    shift   = '0;
                    go(left != 0 ? ST_RX_L : ST_MNACK_A);
                end
                default:
                begin
                    role = RL_STOP;
                    go(ST_STOP_A);
                end
            endcase
        endfunction

        function i2cm_res_t advance(i2cm_item_t it);
            i2cm_res_t r;
            r = '0;
            if (seq == ST_IDLE)
            begin
                if (it.action == ACT_WRITE || it.action == ACT_READ)
                begin
                    held_dev  = it.device_address;
                    held_reg  = it.register_address;
                    held_data = it.write_byte;
                    role      = (it.action == ACT_WRITE) ? RL_W_DEV : RL_R_DEV;
                    if (it.action != ACT_READ)
                        left = '0;
                    else if (it.read_count > MAX_READ_DEF)
                        left = 9'(MAX_READ_DEF);
                    else
                        left = it.read_count;
                    go(ST_START_A);
                end
            end
            else if (seq == ST_ACK_POLL)
            begin
                if (!it.sda_in)
                    acked();
                else if (poll_cnt >= ack_limit)
                begin
                    role = RL_FAULT;
                    go(ST_STOP_A);
                end
                else
                    poll_cnt = poll_cnt + 8'd1;
            end
            else if (phase_done())
            begin
                case (seq)
                    ST_START_A, ST_RSTART_A: go(ST_START_B);
                    ST_START_B: go(ST_START_C);
                    ST_START_C: go(ST_START_D);
                    ST_START_D:
                        send_byte((role == RL_R_DEV1) ? (held_dev | 8'h01) : held_dev, role);
                    ST_TX_L1: go(ST_TX_L2);
                    ST_TX_L2: go(ST_TX_L3);
                    ST_TX_L3: go(ST_TX_H);
                    ST_TX_H:  go(ST_TX_T);
                    ST_TX_T:
                    begin
                        shift   = {shift[6:0], 1'b0};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BIT_LAST)
                        begin
                            poll_cnt = '0;
                            go(ST_ACK_A);
                        end
                        else
                            go(ST_TX_L1);
                    end
                    ST_ACK_A: go(ST_ACK_B);
                    ST_ACK_B: go(ST_ACK_POLL);
                    ST_RX_L:  go(ST_RX_H);
                    ST_RX_H:
                    begin
                        shift   = {shift[6:0], it.sda_in};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BIT_LAST)
                        begin
                            r.read_valid = 1'b1;
                            r.read_byte  = shift;
                            r.read_last  = (left <= 1);
                            if (left > 0)
                                left = left - 9'd1;
                            go(left != 0 ? ST_MACK_A : ST_MNACK_A);
                        end
                        else
                            go(ST_RX_L);
                    end
                    ST_MACK_A: go(ST_MACK_B);
                    ST_MACK_B:
                    begin
                        bit_cnt = '0;
                        shift   = '0;
                        go(ST_RX_L);
                    end
                    ST_MNACK_A: go(ST_MNACK_B);
                    ST_MNACK_B:
                    begin
                        role = RL_STOP;
                        go(ST_STOP_A);
                    end
                    ST_STOP_A: go(ST_STOP_B);
                    ST_STOP_B: go(ST_STOP_C);
                    ST_STOP_C:
                    begin
                        r.done_res  = 1'b1;
                        r.ack_fault = (role == RL_FAULT);
                        role        = RL_W_DEV;
                        go(ST_IDLE);
                    end
                    default: go(ST_IDLE);
                endcase
            end

            r.scl_out = 1'b1;
            r.sda_out = 1'b1;
            case (seq)
                ST_RSTART_A: r.scl_out = 1'b0;
                ST_START_C:  r.sda_out = 1'b0;
                ST_START_D:  {r.scl_out, r.sda_out} = 2'b00;
                ST_TX_L1, ST_TX_L2, ST_TX_L3, ST_TX_T:
                    {r.scl_out, r.sda_out} = {1'b0, shift[7]};
                ST_TX_H:     r.sda_out = shift[7];
                ST_ACK_A, ST_RX_L:
                begin
                    r.scl_out        = 1'b0;
                    r.sda_input_mode = 1'b1;
                end
                ST_ACK_B, ST_ACK_POLL, ST_RX_H: r.sda_input_mode = 1'b1;
                ST_MACK_A:   {r.scl_out, r.sda_out} = 2'b00;
                ST_MACK_B:   r.sda_out = 1'b0;
                ST_MNACK_A:  r.scl_out = 1'b0;
                ST_STOP_A:   {r.scl_out, r.sda_out} = 2'b00;
                ST_STOP_B:   r.sda_out = 1'b0;
                default:     ;
            endcase
            r.busy_res = (seq != ST_IDLE);
            return r;
        endfunction

        function void note_tick(i2cm_item_t it);
            expected_levels.push_back(advance(it));
        endfunction

        function void cmp(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_levels(i2cm_res_t got);
            i2cm_res_t want;
            if (expected_levels.size() == 0)
            begin
                $error("result transaction with no tick waiting for it");
                mismatches++;
                return;
            end
            want = expected_levels.pop_front();
            cmp("scl_out", 8'(want.scl_out), 8'(got.scl_out));
            cmp("sda_out", 8'(want.sda_out), 8'(got.sda_out));
            cmp("sda_input_mode", 8'(want.sda_input_mode), 8'(got.sda_input_mode));
            cmp("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            cmp("done_res", 8'(want.done_res), 8'(got.done_res));
            cmp("ack_fault", 8'(want.ack_fault), 8'(got.ack_fault));
            cmp("read_byte", want.read_byte, got.read_byte);
            cmp("read_valid", 8'(want.read_valid), 8'(got.read_valid));
            cmp("read_last", 8'(want.read_last), 8'(got.read_last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          ack_pct;
    int          items_sent;
    int          item_cap;
    int          phase_end;

    bus_level_scoreboard board;

    i2cm_in_if  in_ch ();
    i2cm_out_if out_ch ();

    i2c_master_register_access_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                board.check_levels({out_ch.scl_out, out_ch.sda_out, out_ch.sda_input_mode,
                                    out_ch.busy_res, out_ch.done_res, out_ch.ack_fault,
                                    out_ch.read_byte, out_ch.read_valid, out_ch.read_last});
            if (in_ch.valid && in_ch.ready)
                board.note_tick({in_ch.action, in_ch.device_address, in_ch.register_address,
                                 in_ch.write_byte, in_ch.read_count, in_ch.sda_in});
            if (cfg_we)
                board.write_reg(cfg_index, cfg_wdata);
        end
    end

    // mostly short reads, now and then a saturating one
    function automatic logic [8:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 9'($urandom_range(0, 2));
        if (r < 98)
            return 9'($urandom_range(3, 4));
        return 9'($urandom_range(257, 511));
    endfunction

    function automatic logic [15:0] pick_phase();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 16'd0;
        if (r < 85)
            return 16'd1;
        return 16'd2;
    endfunction

    function automatic logic [7:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return 8'd0;
        if (r < 30)
            return 8'd255;
        if (r < 40)
            return 8'($urandom);
        return 8'($urandom_range(1, 20));
    endfunction

    // a plain tick; commands are only noise here, the sequencer ignores them while busy
    function automatic i2cm_item_t next_tick();
        i2cm_item_t it;
        it.device_address   = 8'($urandom);
        it.register_address = 8'($urandom);
        it.write_byte       = 8'($urandom);
        it.read_count       = 9'($urandom_range(0, 511));
        if (board.seq == ST_IDLE)
            it.action = $urandom_range(0, 1) ? ACT_TICK : ACT_UNUSED;
        else
            it.action = 2'($urandom_range(0, 3));
        if (board.seq == ST_ACK_POLL)
            it.sda_in = ($urandom_range(0, 99) >= ack_pct);
        else
            it.sda_in = 1'($urandom);
        return it;
    endfunction

    task automatic send_tick(input i2cm_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.action           <= it.action;
        in_ch.device_address   <= it.device_address;
        in_ch.register_address <= it.register_address;
        in_ch.write_byte       <= it.write_byte;
        in_ch.read_count       <= it.read_count;
        in_ch.sda_in           <= it.sda_in;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (board.pending() != 0);
    endtask

    // only called with nothing in flight
    task automatic configure(input logic [15:0] phase, input logic [7:0] timeout);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_wdata <= phase;
        @(negedge clk);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_wdata <= {8'h00, timeout};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic start_command(input logic [1:0] act, input logic [7:0] dev,
                                 input logic [7:0] regaddr, input logic [7:0] data,
                                 input logic [8:0] cnt);
        i2cm_item_t it;
        it.action           = act;
        it.device_address   = dev;
        it.register_address = regaddr;
        it.write_byte       = data;
        it.read_count       = cnt;
        it.sda_in           = 1'($urandom);
        send_tick(it);
    endtask

    // stops early once the tick budget of the current section is used up
    task automatic finish_transfer();
        while (board.seq != ST_IDLE && items_sent < item_cap)
        begin
            if ($urandom_range(0, 999) == 0)
                wait_drained();
            send_tick(next_tick());
        end
    endtask

    task automatic run_transfer(input logic [1:0] act, input logic [7:0] dev,
                                input logic [7:0] regaddr, input logic [7:0] data,
                                input logic [8:0] cnt);
        start_command(act, dev, regaddr, data, cnt);
        finish_transfer();
    endtask

    initial
    begin
        board                  = new();
        send_idle_pct          = 0;
        recv_idle_pct          = 0;
        ack_pct                = 100;
        items_sent             = 0;
        item_cap               = ITEM_TARGET;
        phase_end              = 0;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_PHASE_TICKS;
        cfg_wdata              = '0;
        in_ch.valid            = 1'b0;
        in_ch.action           = ACT_TICK;
        in_ch.device_address   = '0;
        in_ch.register_address = '0;
        in_ch.write_byte       = '0;
        in_ch.read_count       = '0;
        in_ch.sda_in           = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // idle ticks, then a write at the reset bus timing past the end of the first phase
        repeat (3) send_tick(next_tick());
        start_command(ACT_WRITE, 8'h00, 8'hFF, 8'hA5, 9'd0);
        repeat (RESET_PHASE_TICKS) send_tick(next_tick());

        // phase length dropped below the running count, no polls tolerated: fault
        wait_drained();
        configure(16'd0, 8'd0);
        ack_pct = 0;
        finish_transfer();

        // longest poll run before the fault
        wait_drained();
        configure(16'd1, 8'd255);
        run_transfer(ACT_WRITE, 8'h3C, 8'hC3, 8'hFF, 9'd0);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 20 : ((ph == 1) ? 45 : 0);
            recv_idle_pct = (ph == 0) ? 45 : ((ph == 1) ? 20 : 0);
            phase_end     = items_sent + PHASE_ITEMS;
            item_cap      = phase_end + PHASE_ITEMS;
            wait_drained();
            configure(pick_phase(), pick_timeout());
            do
            begin
                ack_pct = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(25, 100);
                repeat ($urandom_range(0, 2)) send_tick(next_tick());
                run_transfer($urandom_range(0, 1) ? ACT_WRITE : ACT_READ, 8'($urandom),
                             8'($urandom), 8'($urandom), pick_count());
            end
            while (items_sent < phase_end);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/i2cm_pkg.sv
rtl/i2cm_in_if.sv
rtl/i2cm_out_if.sv
rtl/i2cm_step.sv
rtl/i2c_master_register_access_top.sv
tb/sv/tb_i2c_master_register_access_top.sv
